// File: src/subclass_count_weight_assert.svh
// Assertion macros shared by the subclass weight block
`ifndef SUBCLASS_COUNT_WEIGHT_ASSERT_SVH
`define SUBCLASS_COUNT_WEIGHT_ASSERT_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define SCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off while rst_n is low
`define SCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/scw_pkg.sv
// Types and constants of the subclass weight block
`default_nettype none

package scw_pkg;

  localparam int unsigned SUBCLASS_ID_W = 9;
  localparam int unsigned WEIGHT_W      = 32;
  localparam int unsigned CFG_INDEX_W   = 1;
  localparam int unsigned CFG_DATA_W    = 1;

  // request codes
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FOCAL_ENABLE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FOCAL_GROUP  = 1'b1;

  typedef struct packed {
    logic [1:0]               req_type;
    logic                     subclass_valid;
    logic [SUBCLASS_ID_W-1:0] subclass_id;
    logic                     treatment;
  } in_item_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                zero_divisor;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_CLEAR
  } state_t;

endpackage

`default_nettype wire

// File: src/subclass_count_weight.sv
// Load: the held item's count is incremented in the execute state unless missing or saturated.
// Clear: every table row is zeroed, one table row per cycle. Query: for a missing subclass, a
// focal unit or a zero divisor the result strobe is registered from the execute state; otherwise
// the one-bit-per-cycle divider computes it. Busy falls with the result strobe; the next item may follow.
// Reset: control registers take their defaults, then a clearing pass over every table row with busy high.
// Results are strobed for one cycle and cannot be held off by the receiver.
`default_nettype none
`include "subclass_count_weight_assert.svh"

module subclass_count_weight #(
  parameter int unsigned NUM_SUBCLASSES = 256,
  parameter int unsigned COUNT_WIDTH    = 16,
  parameter int unsigned FRAC_BITS      = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire scw_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  output scw_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [scw_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [scw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int unsigned ROW_W   = $clog2(NUM_SUBCLASSES);
  localparam int unsigned ROW_BW  = 2 * COUNT_WIDTH;
  localparam int unsigned NUM_W   = COUNT_WIDTH + 1;
  localparam int unsigned QUO_W   = NUM_W + FRAC_BITS;
  localparam int unsigned WGT_W   = scw_pkg::WEIGHT_W;
  localparam int unsigned ID_W    = scw_pkg::SUBCLASS_ID_W;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_SUBCLASSES - 1);

  // one row per subclass: control count in the low half, treated count in the high half
  logic [ROW_BW-1:0] mem [NUM_SUBCLASSES];

  scw_pkg::state_t    state_r;
  scw_pkg::state_t    state_nxt;
  scw_pkg::in_item_t  item_r;
  logic               present_r;
  logic [ROW_W-1:0]   row_r;
  logic [ROW_W-1:0]   clr_row_r;
  logic [ROW_W-1:0]   clr_row_nxt;
  logic [ROW_BW-1:0]  rd_data_r;
  logic               focal_en_r;
  logic               focal_grp_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  scw_pkg::out_item_t out_data_r;
  scw_pkg::out_item_t out_data_nxt;

  logic               accept;
  logic [ID_W-1:0]    sid_m1;
  logic [ROW_W-1:0]   in_row;
  logic               in_present;

  logic [COUNT_WIDTH-1:0] lane0;
  logic [COUNT_WIDTH-1:0] lane1;
  logic [COUNT_WIDTH-1:0] own_cnt;
  logic [COUNT_WIDTH-1:0] focal_cnt;
  logic [NUM_W-1:0]       num;
  logic                   focal_unit;
  logic                   den_zero;
  logic                   own_full;
  logic [ROW_BW-1:0]      inc_row;

  logic                   mem_we;
  logic [ROW_W-1:0]       mem_waddr;
  logic [ROW_BW-1:0]      mem_wdata;

  logic                   div_start;
  logic                   div_done;
  logic [QUO_W-1:0]       div_quo;
  logic [QUO_W+WGT_W-1:0] quo_ext;
  logic [WGT_W-1:0]       quo_sat;

  assign accept     = start && (state_r == scw_pkg::ST_IDLE);
  assign sid_m1     = in_data.subclass_id - ID_W'(1);
  assign in_row     = ROW_W'(sid_m1);
  assign in_present = in_data.subclass_valid && (in_data.subclass_id != '0) &&
                      (32'(in_data.subclass_id) <= NUM_SUBCLASSES);

  // table row as read for the held item
  assign lane0     = rd_data_r[COUNT_WIDTH-1:0];
  assign lane1     = rd_data_r[ROW_BW-1:COUNT_WIDTH];
  assign own_cnt   = item_r.treatment ? lane1 : lane0;
  assign focal_cnt = focal_grp_r ? lane1 : lane0;
  assign num       = focal_en_r ? {1'b0, focal_cnt} : ({1'b0, lane0} + {1'b0, lane1});
  assign focal_unit = focal_en_r && (item_r.treatment == focal_grp_r);
  assign den_zero  = (own_cnt == '0);
  assign own_full  = (own_cnt == {COUNT_WIDTH{1'b1}});
  assign inc_row   = item_r.treatment ? {lane1 + COUNT_WIDTH'(1), lane0}
                                      : {lane1, lane0 + COUNT_WIDTH'(1)};

  // quotients beyond the weight range saturate
  assign quo_ext = {{WGT_W{1'b0}}, div_quo};
  assign quo_sat = (|quo_ext[QUO_W+WGT_W-1:WGT_W]) ? {WGT_W{1'b1}} : quo_ext[WGT_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      scw_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.req_type == scw_pkg::REQ_CLEAR) ? scw_pkg::ST_CLEAR
                                                              : scw_pkg::ST_EXEC;
        end
      end
      scw_pkg::ST_EXEC: begin
        if ((item_r.req_type == scw_pkg::REQ_QUERY) && present_r && !focal_unit &&
            !den_zero) begin
          state_nxt = scw_pkg::ST_DIV;
        end else begin
          state_nxt = scw_pkg::ST_IDLE;
        end
      end
      scw_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = scw_pkg::ST_IDLE;
        end
      end
      scw_pkg::ST_CLEAR: begin
        if (clr_row_r == LAST_ROW) begin
          state_nxt = scw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = scw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = row_r;
    mem_wdata     = inc_row;
    div_start     = 1'b0;
    clr_row_nxt   = clr_row_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '{weight: '0, zero_divisor: 1'b0};
    case (state_r)
      scw_pkg::ST_EXEC: begin
        case (item_r.req_type)
          scw_pkg::REQ_ADD: begin
            mem_we = present_r && !own_full;
          end
          scw_pkg::REQ_QUERY: begin
            if (!present_r) begin
              out_valid_nxt = 1'b1;
            end else if (focal_unit) begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.weight = WGT_W'(1) << FRAC_BITS;
            end else if (den_zero) begin
              out_valid_nxt             = 1'b1;
              out_data_nxt.zero_divisor = 1'b1;
            end else begin
              div_start = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      scw_pkg::ST_DIV: begin
        if (div_done) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.weight = quo_sat;
        end
      end
      scw_pkg::ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_row_r;
        mem_wdata   = '0;
        // wrap to row zero so the next pass starts there
        clr_row_nxt = (clr_row_r == LAST_ROW) ? '0 : clr_row_r + ROW_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scw_pkg::ST_CLEAR;
      clr_row_r   <= '0;
      out_valid_r <= 1'b0;
      focal_en_r  <= 1'b0;
      focal_grp_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          scw_pkg::CFG_FOCAL_ENABLE: focal_en_r  <= cfg_wdata[0];
          scw_pkg::CFG_FOCAL_GROUP:  focal_grp_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r    <= in_data;
      present_r <= in_present;
      row_r     <= in_row;
    end
    out_data_r <= out_data_nxt;
  end

  // count table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[in_row];
  end

  scw_div #(
    .NUM_W     (NUM_W),
    .DEN_W     (COUNT_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (own_cnt),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign busy      = (state_r != scw_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SCW_ASSERT_NOW(a_out_from_work, out_valid_r,
    ($past(state_r) == scw_pkg::ST_EXEC) || ($past(state_r) == scw_pkg::ST_DIV),
    "result strobe without a query in progress")
  `SCW_ASSERT_NEXT(a_accept_exec, accept && (in_data.req_type != scw_pkg::REQ_CLEAR),
    state_r == scw_pkg::ST_EXEC, "accepted item did not reach the table read")
  `SCW_ASSERT_NOW(a_div_done_state, div_done, state_r == scw_pkg::ST_DIV,
    "divider finished outside the divide state")
  `SCW_ASSERT_NOW(a_zero_div_weight, out_valid_r && out_data_r.zero_divisor,
    out_data_r.weight == '0, "zero divisor flagged with a non-zero weight")

endmodule

`default_nettype wire

// File: src/scw_div.sv
// Restoring divider, one quotient bit per cycle, for fixed-point count ratios
`default_nettype none

module scw_div #(
  parameter int unsigned NUM_W     = 17,
  parameter int unsigned DEN_W     = 16,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [NUM_W-1:0]             num,
  input  wire logic [DEN_W-1:0]             den,
  output logic                              done,
  output logic [NUM_W+FRAC_BITS-1:0]        quo
);

  localparam int unsigned QUO_W = NUM_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic              busy_r;
  logic              busy_nxt;
  logic              done_r;
  logic              done_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [QUO_W-1:0]  quo_r;
  logic [QUO_W-1:0]  quo_nxt;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  rem_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    diff;
  logic              fits;

  // dividend bits shift out of the top of quo_r while quotient bits enter at the bottom
  assign rem_sh = {rem_r, quo_r[QUO_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign fits   = (rem_sh >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QUO_W);
      quo_nxt  = {num, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[QUO_W-2:0], fits};
      rem_nxt = fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire
